// File: rtl/grid_trilinear_sampler_assert.svh
// Assertion macros used by the sampler controller.
`ifndef GRID_TRILINEAR_SAMPLER_ASSERT_SVH
`define GRID_TRILINEAR_SAMPLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GTS_ASSERT_IMP(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GTS_ASSERT_NXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/gts_pkg.sv
// Shared constants, types and helper functions of the grid sampler.
`timescale 1ns / 1ps
package gts_pkg;

	localparam int STORE_DEPTH = 65536;
	localparam int MAX_GHOST   = 64;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int IW          = AW + 1;
	localparam int SW          = 2 * IW + 24;
	localparam logic [IW-1:0] IDX_CAP = '1;

	localparam int N_IDX_STEPS = 6;
	localparam int N_CORNERS   = 8;
	localparam int N_LERPS     = 7;

	localparam logic [1:0] CMD_RESTART = 2'd0;
	localparam logic [1:0] CMD_APPEND  = 2'd1;
	localparam logic [1:0] CMD_SAMPLE  = 2'd2;

	localparam logic [2:0] REG_BOX_LOW   = 3'd0;
	localparam logic [2:0] REG_BOX_HIGH  = 3'd1;
	localparam logic [2:0] REG_GHOST     = 3'd2;
	localparam logic [2:0] REG_COMPS     = 3'd3;
	localparam logic [2:0] REG_INV_SPACE = 3'd4;
	localparam logic [2:0] REG_CENTER_X  = 3'd5;
	localparam logic [2:0] REG_CENTER_Y  = 3'd6;
	localparam logic [2:0] REG_CENTER_Z  = 3'd7;

	typedef enum logic [3:0] {
		OP_IDLE, OP_LOAD, OP_SIMPLE, OP_CHECK, OP_GLO, OP_GHI, OP_GFIN,
		OP_AXIS, OP_IDX, OP_READ, OP_LMUL, OP_LADD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] sel;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
	} dp_stat_t;

	// Clip a wide nonnegative value to the index range; the cap reads as out of store.
	function automatic logic [IW-1:0] sat_idx(input logic [SW-1:0] v);
		return (v >= SW'(IDX_CAP)) ? IDX_CAP : v[IW-1:0];
	endfunction

	// Lerp k overwrites corner dst with a blend toward corner src.
	function automatic logic [2:0] lerp_dst(input logic [2:0] k);
		logic [2:0] r;
		unique case (k)
			3'd1:    r = 3'd2;
			3'd2:    r = 3'd4;
			3'd3:    r = 3'd6;
			3'd5:    r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] lerp_src(input logic [2:0] k);
		logic [2:0] r;
		unique case (k)
			3'd0:    r = 3'd1;
			3'd1:    r = 3'd3;
			3'd2:    r = 3'd5;
			3'd3:    r = 3'd7;
			3'd4:    r = 3'd2;
			3'd5:    r = 3'd6;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] lerp_axis(input logic [2:0] k);
		logic [1:0] r;
		unique case (k)
			3'd0, 3'd1, 3'd2, 3'd3: r = 2'd0;
			3'd4, 3'd5:             r = 2'd1;
			default:                r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/gts_ctrl.sv
// Sequencing state machine of the grid sampler.
`timescale 1ns / 1ps
`include "grid_trilinear_sampler_assert.svh"
module gts_ctrl import gts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_GLO, S_GHI, S_GFIN, S_AXIS, S_IDX, S_READ,
		S_LMUL, S_LADD, S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] axis_q;
	logic [3:0] cnt_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op       = OP_IDLE;
		cmd.sel      = 4'd0;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_IDLE;
			S_DECODE: cmd.op = (stat.kind == CMD_SAMPLE) ? OP_CHECK : OP_SIMPLE;
			S_GLO: begin
				cmd.op  = OP_GLO;
				cmd.sel = {2'b00, axis_q};
			end
			S_GHI: begin
				cmd.op  = OP_GHI;
				cmd.sel = {2'b00, axis_q};
			end
			S_GFIN: begin
				cmd.op  = OP_GFIN;
				cmd.sel = {2'b00, axis_q};
			end
			S_AXIS: begin
				cmd.op  = OP_AXIS;
				cmd.sel = {2'b00, axis_q};
			end
			S_IDX: begin
				cmd.op  = OP_IDX;
				cmd.sel = cnt_q;
			end
			S_READ: begin
				cmd.op  = OP_READ;
				cmd.sel = cnt_q;
			end
			S_LMUL: begin
				cmd.op  = OP_LMUL;
				cmd.sel = cnt_q;
			end
			S_LADD: begin
				cmd.op  = OP_LADD;
				cmd.sel = cnt_q;
			end
			S_DONE:   cmd.out_load = !out_valid_q || out_ready;
			default:  cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 2'd0;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					axis_q  <= 2'd0;
					state_q <= (stat.kind == CMD_SAMPLE) ? S_GLO : S_DONE;
				end
				S_GLO:  state_q <= S_GHI;
				S_GHI:  state_q <= S_GFIN;
				S_GFIN: begin
					if (axis_q == 2'd2) begin
						axis_q  <= 2'd0;
						state_q <= S_AXIS;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_GLO;
					end
				end
				S_AXIS: begin
					cnt_q <= 4'd0;
					if (axis_q == 2'd2) begin
						state_q <= S_IDX;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
				S_IDX: begin
					if (cnt_q == 4'(N_IDX_STEPS - 1)) begin
						cnt_q   <= 4'd0;
						state_q <= S_READ;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_READ: begin
					if (cnt_q == 4'(N_CORNERS)) begin
						cnt_q   <= 4'd0;
						state_q <= S_LMUL;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_LMUL: state_q <= S_LADD;
				S_LADD: begin
					if (cnt_q == 4'(N_LERPS - 1)) begin
						state_q <= S_DONE;
					end else begin
						cnt_q   <= cnt_q + 4'd1;
						state_q <= S_LMUL;
					end
				end
				S_DONE: begin
					if (cmd.out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`GTS_ASSERT_NXT(a_accept_decodes, in_valid && in_ready, state_q == S_DECODE)
	`GTS_ASSERT_IMP(a_load_has_room, cmd.out_load, !out_valid_q || out_ready)
	`GTS_ASSERT_IMP(a_read_count, state_q == S_READ, cnt_q <= 4'(N_CORNERS))

endmodule

// File: rtl/gts_dpath.sv
// Datapath of the grid sampler: registers, cell store, multipliers and lerp unit.
`timescale 1ns / 1ps
module gts_dpath import gts_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [2:0]   cfg_addr,
	input  logic [47:0]  cfg_wdata,
	input  logic [135:0] in_data,
	input  logic [1:0]   in_kind,
	input  logic         in_last,
	input  dp_cmd_t      cmd,
	output dp_stat_t     stat,
	output logic [39:0]  out_data
);

	logic [47:0]        box_low_q, box_high_q;
	logic [6:0]         ghost_q, comps_q;
	logic [31:0]        inv_q;
	logic signed [31:0] ctr_q [3];

	logic [1:0]         kind_q;
	logic [31:0]        word_q;
	logic               last_q;
	logic signed [31:0] pos_q [3];
	logic [5:0]         comp_q;
	logic               near_q, clamp_q;

	logic [IW-1:0]      fill_q;
	logic               loaded_q, res_ok_q, fail_q;

	logic [64:0]        prod_q;
	logic signed [50:0] g_q [3];
	logic [IW-1:0]      cb_q [3];
	logic               step_q [3];
	logic [16:0]        w_q [3];
	logic [IW-1:0]      p01_q, sy_q, sz_q, base_q;
	logic signed [31:0] c_q [8];
	logic signed [50:0] lprod_q;
	logic [31:0]        rd_q;
	logic [31:0]        val_q;
	logic               ok_q;

	logic [31:0] mem [STORE_DEPTH];

	assign stat.kind = kind_q;
	assign out_data  = {7'd0, ok_q, val_q};

	// Box geometry.
	logic signed [16:0] lo_ax [3], hi_ax [3];
	logic [IW-1:0]      span [3];
	logic [IW-1:0]      cc_i, comp_i;
	logic               inverted;

	always_comb begin
		logic signed [18:0] s;
		inverted = 1'b0;
		for (int d = 0; d < 3; d++) begin
			lo_ax[d] = 17'($signed(box_low_q[16*d +: 16]));
			hi_ax[d] = 17'($signed(box_high_q[16*d +: 16]));
			if (hi_ax[d] < lo_ax[d]) inverted = 1'b1;
			s = 19'(hi_ax[d]) - 19'(lo_ax[d]) + 19'sd1 + $signed({11'd0, ghost_q, 1'b0});
			span[d] = s[18] ? '0 : sat_idx(SW'(s));
		end
		cc_i   = sat_idx(SW'(comps_q));
		comp_i = sat_idx(SW'(comp_q));
	end

	logic       add_ok;
	assign add_ok = (fill_q < IW'(STORE_DEPTH));

	// Grid coordinate of the selected axis.
	logic [1:0]         ax;
	logic signed [32:0] psum;
	logic [32:0]        mag;
	logic [64:0]        prod_up;
	logic signed [50:0] qv;
	assign ax      = cmd.sel[1:0];
	assign psum    = 33'(pos_q[ax]) + 33'(ctr_q[ax]);
	assign mag     = psum[32] ? 33'(-psum) : 33'(psum);
	assign prod_up = prod_q + 65'h0FFFF;
	assign qv      = psum[32] ? -$signed({2'b00, prod_up[64:16]}) : $signed({2'b00, prod_q[64:16]});

	// Per-axis base cell, weight and step.
	logic signed [50:0] bsel, tsel, cm, lo51, hi51, gp, gn, rn, fb, gx;
	logic [16:0]        wsel;
	logic               ax_fail;
	always_comb begin
		gx   = g_q[ax];
		lo51 = 51'(lo_ax[ax]);
		hi51 = 51'(hi_ax[ax]);
		gp   = gx + 51'sd32768;
		gn   = -gx + 51'sd32768;
		rn   = gx[50] ? -(gn >>> 16) : (gp >>> 16);
		fb   = gx >>> 16;
		ax_fail = 1'b0;
		if (near_q) begin
			bsel = rn;
			wsel = 17'd0;
			if (clamp_q) begin
				if (bsel > hi51) bsel = hi51;
				if (bsel < lo51) bsel = lo51;
			end else if (bsel < lo51 || bsel > hi51) begin
				ax_fail = 1'b1;
			end
			tsel = bsel;
		end else begin
			bsel = fb;
			wsel = {1'b0, gx[15:0]};
			if (clamp_q) begin
				if (hi51 <= lo51) begin
					bsel = lo51;
					wsel = 17'd0;
				end else begin
					if (bsel < lo51) begin
						bsel = lo51;
						wsel = 17'd0;
					end
					if (bsel >= hi51) begin
						bsel = hi51 - 51'sd1;
						wsel = 17'd65536;
					end
				end
			end else if (bsel < lo51 || bsel >= hi51) begin
				ax_fail = 1'b1;
			end
			tsel = (bsel + 51'sd1 < hi51) ? bsel + 51'sd1 : hi51;
		end
		cm = bsel - lo51 + 51'($signed({1'b0, ghost_q}));
	end

	// Shared index multiplier.
	logic [IW-1:0]   ma, mb, madd, mres;
	logic [2*IW-1:0] mprod;
	always_comb begin
		unique case (cmd.sel[2:0])
			3'd0: begin ma = span[0]; mb = span[1]; madd = '0;        end
			3'd1: begin ma = span[0]; mb = cc_i;    madd = '0;        end
			3'd2: begin ma = p01_q;   mb = cc_i;    madd = '0;        end
			3'd3: begin ma = cb_q[2]; mb = span[1]; madd = cb_q[1];   end
			3'd4: begin ma = base_q;  mb = span[0]; madd = cb_q[0];   end
			default: begin ma = base_q; mb = cc_i;  madd = comp_i;    end
		endcase
		mprod = (2*IW)'(ma) * (2*IW)'(mb);
		mres  = sat_idx(SW'(mprod) + SW'(madd));
	end

	// Corner word index.
	logic [2:0]    cn;
	logic [IW-1:0] cidx;
	assign cn   = cmd.sel[2:0];
	assign cidx = sat_idx(SW'(base_q)
		+ ((cn[0] && step_q[0]) ? SW'(cc_i) : SW'(0))
		+ ((cn[1] && step_q[1]) ? SW'(sy_q) : SW'(0))
		+ ((cn[2] && step_q[2]) ? SW'(sz_q) : SW'(0)));

	// Lerp operands.
	logic [2:0]         ldst, lsrc;
	logic signed [32:0] ldiff;
	logic signed [50:0] lround;
	assign ldst   = lerp_dst(cmd.sel[2:0]);
	assign lsrc   = lerp_src(cmd.sel[2:0]);
	assign ldiff  = 33'(c_q[lsrc]) - 33'(c_q[ldst]);
	assign lround = (lprod_q + 51'sd32768) >>> 16;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_SIMPLE && kind_q == CMD_APPEND && add_ok) begin
			mem[fill_q[AW-1:0]] <= word_q;
		end
		if (cmd.op == OP_READ && !cmd.sel[3]) begin
			rd_q <= mem[cidx[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_low_q  <= 48'd0;
			box_high_q <= '1;
			ghost_q    <= 7'd0;
			comps_q    <= 7'd0;
			inv_q      <= 32'd65536;
			ctr_q[0]   <= 32'sd0;
			ctr_q[1]   <= 32'sd0;
			ctr_q[2]   <= 32'sd0;
			fill_q     <= '0;
			loaded_q   <= 1'b0;
			kind_q     <= CMD_RESTART;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_addr)
					REG_BOX_LOW:   box_low_q  <= cfg_wdata;
					REG_BOX_HIGH:  box_high_q <= cfg_wdata;
					REG_GHOST:     ghost_q    <= cfg_wdata[6:0];
					REG_COMPS:     comps_q    <= cfg_wdata[6:0];
					REG_INV_SPACE: inv_q      <= cfg_wdata[31:0];
					REG_CENTER_X:  ctr_q[0]   <= $signed(cfg_wdata[31:0]);
					REG_CENTER_Y:  ctr_q[1]   <= $signed(cfg_wdata[31:0]);
					REG_CENTER_Z:  ctr_q[2]   <= $signed(cfg_wdata[31:0]);
				endcase
			end
			if (cmd.op == OP_LOAD) kind_q <= in_kind;
			if (cmd.op == OP_SIMPLE) begin
				if (kind_q == CMD_RESTART) begin
					fill_q   <= '0;
					loaded_q <= 1'b0;
				end else if (kind_q == CMD_APPEND) begin
					if (add_ok) fill_q <= fill_q + IW'(1);
					if (last_q) loaded_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				word_q   <= in_data[31:0];
				pos_q[0] <= $signed(in_data[63:32]);
				pos_q[1] <= $signed(in_data[95:64]);
				pos_q[2] <= $signed(in_data[127:96]);
				comp_q   <= in_data[133:128];
				near_q   <= in_data[134];
				clamp_q  <= in_data[135];
				last_q   <= in_last;
			end
			OP_SIMPLE: begin
				unique case (kind_q)
					CMD_RESTART: res_ok_q <= 1'b1;
					CMD_APPEND:  res_ok_q <= add_ok;
					default:     res_ok_q <= 1'b0;
				endcase
			end
			OP_CHECK: fail_q <= !loaded_q || (ghost_q > 7'(MAX_GHOST)) || inverted
				|| (comp_i >= cc_i);
			OP_GLO:   prod_q <= 65'(mag[16:0] * inv_q);
			OP_GHI:   prod_q <= prod_q + (65'(mag[32:17] * inv_q) << 17);
			OP_GFIN:  g_q[ax] <= qv - 51'sd32768;
			OP_AXIS: begin
				if (ax_fail) fail_q <= 1'b1;
				w_q[ax]    <= wsel;
				step_q[ax] <= (tsel != bsel);
				if (cm < 51'sd0) begin
					cb_q[ax] <= '0;
				end else if (cm >= 51'(IDX_CAP)) begin
					cb_q[ax] <= IDX_CAP;
				end else begin
					cb_q[ax] <= cm[IW-1:0];
				end
			end
			OP_IDX: begin
				unique case (cmd.sel[2:0])
					3'd0:    p01_q  <= mres;
					3'd1:    sy_q   <= mres;
					3'd2:    sz_q   <= mres;
					default: base_q <= mres;
				endcase
			end
			OP_READ: begin
				if (!cmd.sel[3] && cidx >= fill_q) fail_q <= 1'b1;
				if (cmd.sel != 4'd0) c_q[3'(cmd.sel - 4'd1)] <= $signed(rd_q);
			end
			OP_LMUL:  lprod_q <= 51'(ldiff * $signed({1'b0, w_q[lerp_axis(cmd.sel[2:0])]}));
			OP_LADD:  c_q[ldst] <= c_q[ldst] + 32'(lround);
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			if (kind_q == CMD_SAMPLE) begin
				val_q <= fail_q ? 32'd0 : c_q[0];
				ok_q  <= !fail_q;
			end else begin
				val_q <= 32'd0;
				ok_q  <= res_ok_q;
			end
		end
	end

endmodule

// File: rtl/grid_trilinear_sampler.sv
// Top level of the grid sampler: ports, field packing and the two submodules.
`timescale 1ns / 1ps
//
// Channel   Direction  Contents
// s_*       in         one request: restart, append word or sample point
// m_*       out        one result per request: value and ok flag
// cfg_*     in         register writes, index per register list
//
// A restart or append request passes the accept, decode and output load states.
// A sample request passes the accept and decode states, the three grid coordinates
// (a 17x32 and a 16x32 partial product and a finishing step per axis), three
// axis steps, six index steps on one shared multiplier, reads of the eight
// corners from the single-ported cell store, seven lerps of a multiply and an
// add step each on one lerp multiplier, and the state that loads the output.
// Reset clears the load state and restores the register defaults; the cell
// store itself is not cleared, reads are guarded by the fill count.
// A finished result waits in the output register while the next request is
// taken; the block stalls only when a second result is ready before the
// first has been taken.
module grid_trilinear_sampler import gts_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// data_word[31:0], pos_x[63:32], pos_y[95:64], pos_z[127:96],
	// component[133:128], nearest_mode[134], clamp_mode[135]
	input  logic [135:0] s_tdata,
	input  logic         s_tlast,   // final_word
	input  logic [1:0]   s_tuser,   // command
	output logic         m_tvalid,
	input  logic         m_tready,
	// sample_value[31:0], sample_ok[32], zero fill above
	output logic [39:0]  m_tdata,
	input  logic         cfg_wen,
	input  logic [2:0]   cfg_addr,
	input  logic [47:0]  cfg_wdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller sequences every request; the datapath only follows its commands.
	gts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gts_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.in_kind   (s_tuser),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

endmodule
